/* hw/rtl/frsr_pkg.sv */
// Package of the flash record slot rotator: codes, control word layout and
// small helper functions. No dependencies.
package frsr_pkg;

    localparam int MASK_W   = 64;
    localparam int UPC_W    = 5;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 13;

    // Request operations.
    localparam logic [2:0] OP_WRITE_FIRST = 3'd0;
    localparam logic [2:0] OP_OVERRIDE    = 3'd1;
    localparam logic [2:0] OP_LOCATE      = 3'd2;
    localparam logic [2:0] OP_FORMAT      = 3'd3;
    localparam logic [2:0] OP_LOAD_MASK   = 3'd4;

    // Flash commands.
    localparam logic [1:0] CMD_READ   = 2'd0;
    localparam logic [1:0] CMD_WRITE  = 2'd1;
    localparam logic [1:0] CMD_ERASE  = 2'd2;
    localparam logic [1:0] CMD_HEADER = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_RECORD_SIZE = 1'b1;

    // Record pointer actions.
    localparam logic [1:0] REC_HOLD = 2'd0;
    localparam logic [1:0] REC_INC  = 2'd1;
    localparam logic [1:0] REC_ZERO = 2'd2;
    localparam logic [1:0] REC_REQ  = 2'd3;

    // Mask store actions.
    localparam logic [1:0] MSK_NONE  = 2'd0;
    localparam logic [1:0] MSK_SHIFT = 2'd1;
    localparam logic [1:0] MSK_ONES  = 2'd2;

    // Last-word marking.
    localparam logic [1:0] LST_NO   = 2'd0;
    localparam logic [1:0] LST_YES  = 2'd1;
    localparam logic [1:0] LST_LOOP = 2'd2;

    // Sequencer branch conditions.
    localparam logic [2:0] CND_NEXT      = 3'd0;
    localparam logic [2:0] CND_DONE      = 3'd1;
    localparam logic [2:0] CND_IF_ZERO   = 3'd2;
    localparam logic [2:0] CND_IF_NOTONE = 3'd3;
    localparam logic [2:0] CND_LOOP_NEXT = 3'd4;
    localparam logic [2:0] CND_LOOP_DONE = 3'd5;

    // Microprogram entry points and branch targets.
    localparam logic [UPC_W-1:0] UA_WFIRST   = 5'd0;
    localparam logic [UPC_W-1:0] UA_OVERRIDE = 5'd4;
    localparam logic [UPC_W-1:0] UA_COMPACT  = 5'd9;
    localparam logic [UPC_W-1:0] UA_RD_LOOP  = 5'd10;
    localparam logic [UPC_W-1:0] UA_WR_LOOP  = 5'd16;
    localparam logic [UPC_W-1:0] UA_LOCATE   = 5'd20;
    localparam logic [UPC_W-1:0] UA_FORMAT   = 5'd24;

    typedef struct packed {
        logic             emit;
        logic [1:0]       cmd;
        logic [1:0]       last;
        logic             from_buf;
        logic             skip_self;
        logic [1:0]       rec_act;
        logic [1:0]       mask_act;
        logic [2:0]       cond;
        logic [UPC_W-1:0] target;
    } t_ctl;

    typedef struct packed {
        logic mask_ones;
        logic mask_zero;
        logic at_end;
    } t_flags;

    typedef struct packed {
        logic             go;
        logic [UPC_W-1:0] upc;
    } t_disp;

    // Where a request starts in the microprogram; load mask and unknown
    // operations run no program.
    function automatic t_disp op_entry(input logic [2:0] op);
        t_disp d;
        d.go  = 1'b1;
        d.upc = UA_WFIRST;
        unique case (op)
            OP_WRITE_FIRST: d.upc = UA_WFIRST;
            OP_OVERRIDE:    d.upc = UA_OVERRIDE;
            OP_LOCATE:      d.upc = UA_LOCATE;
            OP_FORMAT:      d.upc = UA_FORMAT;
            default:        d.go  = 1'b0;
        endcase
        return d;
    endfunction

    // Leading zeros of one byte; meaningful only for a nonzero byte.
    function automatic logic [2:0] byte_lzc(input logic [7:0] b);
        logic [2:0] n;
        logic       found;
        n     = '0;
        found = 1'b0;
        for (int i = 7; i >= 0; i--) begin
            if (!found) begin
                if (b[i]) begin
                    found = 1'b1;
                end else begin
                    n = n + 3'd1;
                end
            end
        end
        return n;
    endfunction

endpackage

/* hw/rtl/frsr_ucode_rom.sv */
// Microprogram read-only table of the slot rotator sequencer.
// Depends on frsr_pkg for the control word layout and codes.
module frsr_ucode_rom (
    input  logic [frsr_pkg::UPC_W-1:0] i_upc,
    output frsr_pkg::t_ctl             o_ctl
);
    import frsr_pkg::*;

    function automatic t_ctl mk(input logic e, input logic [1:0] c, input logic [1:0] l,
                                input logic fb, input logic sk, input logic [1:0] ra,
                                input logic [1:0] ma, input logic [2:0] cd,
                                input logic [UPC_W-1:0] tg);
        t_ctl w;
        w.emit      = e;
        w.cmd       = c;
        w.last      = l;
        w.from_buf  = fb;
        w.skip_self = sk;
        w.rec_act   = ra;
        w.mask_act  = ma;
        w.cond      = cd;
        w.target    = tg;
        return w;
    endfunction

    // Three steps, some emitting a header, lie between a change of the record or
    // its mask and the next read or write step while the address pipeline settles.
    always_comb begin
        unique case (i_upc)
            // Write first: fresh record goes to slot 0, else behave as override.
            5'd0:  o_ctl = mk(1'b0, CMD_READ, LST_NO, 1'b0, 1'b0, REC_HOLD, MSK_NONE,
                              CND_IF_NOTONE, UA_OVERRIDE);
            5'd1:  o_ctl = mk(1'b0, CMD_READ, LST_NO, 1'b0, 1'b0, REC_HOLD, MSK_NONE,
                              CND_NEXT, UA_WFIRST);
            5'd2:  o_ctl = mk(1'b0, CMD_READ, LST_NO, 1'b0, 1'b0, REC_HOLD, MSK_NONE,
                              CND_NEXT, UA_WFIRST);
            5'd3:  o_ctl = mk(1'b1, CMD_WRITE, LST_YES, 1'b0, 1'b0, REC_HOLD, MSK_NONE,
                              CND_DONE, UA_WFIRST);
            // Override: shift (a zero mask stays zero and branches to compaction).
            5'd4:  o_ctl = mk(1'b0, CMD_READ, LST_NO, 1'b0, 1'b0, REC_HOLD, MSK_SHIFT,
                              CND_IF_ZERO, UA_COMPACT);
            5'd5:  o_ctl = mk(1'b1, CMD_HEADER, LST_NO, 1'b0, 1'b0, REC_HOLD, MSK_NONE,
                              CND_NEXT, UA_WFIRST);
            5'd6:  o_ctl = mk(1'b0, CMD_READ, LST_NO, 1'b0, 1'b0, REC_HOLD, MSK_NONE,
                              CND_NEXT, UA_WFIRST);
            5'd7:  o_ctl = mk(1'b0, CMD_READ, LST_NO, 1'b0, 1'b0, REC_HOLD, MSK_NONE,
                              CND_NEXT, UA_WFIRST);
            5'd8:  o_ctl = mk(1'b1, CMD_WRITE, LST_YES, 1'b0, 1'b0, REC_HOLD, MSK_NONE,
                              CND_DONE, UA_WFIRST);
            // Compaction: read every other record.
            5'd9:  o_ctl = mk(1'b0, CMD_READ, LST_NO, 1'b0, 1'b0, REC_ZERO, MSK_NONE,
                              CND_NEXT, UA_WFIRST);
            5'd10: o_ctl = mk(1'b0, CMD_READ, LST_NO, 1'b0, 1'b0, REC_HOLD, MSK_NONE,
                              CND_NEXT, UA_WFIRST);
            5'd11: o_ctl = mk(1'b0, CMD_READ, LST_NO, 1'b0, 1'b0, REC_HOLD, MSK_NONE,
                              CND_NEXT, UA_WFIRST);
            5'd12: o_ctl = mk(1'b0, CMD_READ, LST_NO, 1'b0, 1'b0, REC_HOLD, MSK_NONE,
                              CND_NEXT, UA_WFIRST);
            5'd13: o_ctl = mk(1'b1, CMD_READ, LST_NO, 1'b0, 1'b1, REC_INC, MSK_NONE,
                              CND_LOOP_NEXT, UA_RD_LOOP);
            // Erase, all-ones header, then rewrite every record at slot 0.
            5'd14: o_ctl = mk(1'b1, CMD_ERASE, LST_NO, 1'b0, 1'b0, REC_REQ, MSK_ONES,
                              CND_NEXT, UA_WFIRST);
            5'd15: o_ctl = mk(1'b1, CMD_HEADER, LST_NO, 1'b0, 1'b0, REC_ZERO, MSK_NONE,
                              CND_NEXT, UA_WFIRST);
            5'd16: o_ctl = mk(1'b0, CMD_READ, LST_NO, 1'b0, 1'b0, REC_HOLD, MSK_NONE,
                              CND_NEXT, UA_WFIRST);
            5'd17: o_ctl = mk(1'b0, CMD_READ, LST_NO, 1'b0, 1'b0, REC_HOLD, MSK_NONE,
                              CND_NEXT, UA_WFIRST);
            5'd18: o_ctl = mk(1'b0, CMD_READ, LST_NO, 1'b0, 1'b0, REC_HOLD, MSK_NONE,
                              CND_NEXT, UA_WFIRST);
            5'd19: o_ctl = mk(1'b1, CMD_WRITE, LST_LOOP, 1'b1, 1'b0, REC_INC, MSK_NONE,
                              CND_LOOP_DONE, UA_WR_LOOP);
            // Locate for read.
            5'd20: o_ctl = mk(1'b0, CMD_READ, LST_NO, 1'b0, 1'b0, REC_HOLD, MSK_NONE,
                              CND_NEXT, UA_WFIRST);
            5'd21: o_ctl = mk(1'b0, CMD_READ, LST_NO, 1'b0, 1'b0, REC_HOLD, MSK_NONE,
                              CND_NEXT, UA_WFIRST);
            5'd22: o_ctl = mk(1'b0, CMD_READ, LST_NO, 1'b0, 1'b0, REC_HOLD, MSK_NONE,
                              CND_NEXT, UA_WFIRST);
            5'd23: o_ctl = mk(1'b1, CMD_READ, LST_YES, 1'b0, 1'b0, REC_HOLD, MSK_NONE,
                              CND_DONE, UA_WFIRST);
            // Format.
            5'd24: o_ctl = mk(1'b1, CMD_ERASE, LST_NO, 1'b0, 1'b0, REC_HOLD, MSK_ONES,
                              CND_NEXT, UA_WFIRST);
            5'd25: o_ctl = mk(1'b1, CMD_HEADER, LST_YES, 1'b0, 1'b0, REC_HOLD, MSK_NONE,
                              CND_DONE, UA_WFIRST);
            default: o_ctl = mk(1'b0, CMD_READ, LST_NO, 1'b0, 1'b0, REC_HOLD, MSK_NONE,
                                CND_DONE, UA_WFIRST);
        endcase
    end

endmodule

/* hw/rtl/frsr_sequencer.sv */
// Step counter and branch logic of the slot rotator microcode sequencer.
// Depends on frsr_pkg and frsr_ucode_rom.
module frsr_sequencer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [2:0]           i_operation,
    input  logic                 i_req_ok,
    input  frsr_pkg::t_flags     i_flags,
    output frsr_pkg::t_ctl       o_ctl,
    output logic                 o_busy
);
    import frsr_pkg::*;

    logic             r_run;
    logic [UPC_W-1:0] r_upc;
    logic             n_run;
    logic [UPC_W-1:0] n_upc;
    t_ctl             rom_ctl;
    t_disp            disp;

    frsr_ucode_rom u_rom (
        .i_upc (r_upc),
        .o_ctl (rom_ctl)
    );

    assign disp = op_entry(i_operation);

    always_comb begin
        n_run = r_run;
        n_upc = r_upc + UPC_W'(1);
        if (!r_run) begin
            n_upc = r_upc;
            if (i_accept && i_req_ok && disp.go) begin
                n_run = 1'b1;
                n_upc = disp.upc;
            end
        end else begin
            unique case (rom_ctl.cond)
                CND_NEXT: ;
                CND_DONE: n_run = 1'b0;
                CND_IF_ZERO: begin
                    if (i_flags.mask_zero) n_upc = rom_ctl.target;
                end
                CND_IF_NOTONE: begin
                    if (!i_flags.mask_ones) n_upc = rom_ctl.target;
                end
                CND_LOOP_NEXT: begin
                    if (!i_flags.at_end) n_upc = rom_ctl.target;
                end
                CND_LOOP_DONE: begin
                    if (!i_flags.at_end) begin
                        n_upc = rom_ctl.target;
                    end else begin
                        n_run = 1'b0;
                    end
                end
                default: n_run = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_upc <= '0;
        end else begin
            r_run <= n_run;
            r_upc <= n_upc;
        end
    end

    // While idle the datapath sees a word that does nothing.
    always_comb begin
        o_ctl = rom_ctl;
        if (!r_run) begin
            o_ctl.emit     = 1'b0;
            o_ctl.rec_act  = REC_HOLD;
            o_ctl.mask_act = MSK_NONE;
        end
    end

    assign o_busy = r_run;

endmodule

/* hw/rtl/frsr_datapath.sv */
// Datapath of the slot rotator: mask store, slot and address pipeline,
// configuration registers and the registered output word. Depends on frsr_pkg.
module frsr_datapath #(
    parameter int RECORDS      = 8,
    parameter int SECTOR_BYTES = 65536
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_accept,
    input  logic [2:0]                           i_operation,
    input  logic [2:0]                           i_pad_index,
    input  logic [frsr_pkg::MASK_W-1:0]          i_mask_value,
    input  logic                                 i_req_ok,
    input  logic                                 i_cfg_we,
    input  logic [frsr_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [frsr_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  frsr_pkg::t_ctl                       i_ctl,
    output frsr_pkg::t_flags                     o_flags,
    output logic                                 o_valid,
    output logic [1:0]                           o_command,
    output logic [15:0]                          o_address,
    output logic [2:0]                           o_record_pad,
    output logic [frsr_pkg::MASK_W-1:0]          o_pad_mask,
    output logic                                 o_record_from_buffer,
    output logic                                 o_beyond_sector,
    output logic                                 o_last
);
    import frsr_pkg::*;

    localparam int RW = (RECORDS > 1) ? $clog2(RECORDS) : 1;
    localparam int IW = $clog2(65 * RECORDS);
    localparam int PW = IW + 8;
    localparam int SW = ((PW > 17) ? PW : 17) + 1;

    logic [MASK_W-1:0]     r_masks [RECORDS];
    logic [RW-1:0]         r_rec;
    logic [RW-1:0]         r_req;
    logic [12:0]           r_hdr_size;
    logic [7:0]            r_rec_size;
    logic [7:0]            r_bnz;
    logic [2:0]            r_blz [8];
    logic [6:0]            r_slot;
    logic [PW-1:0]         r_prod;

    logic [MASK_W-1:0]     cur_mask;
    logic                  at_end;
    logic                  is_self;
    logic [6:0]            n_slot;
    logic [IW-1:0]         n_idx;
    logic [SW-1:0]         sum;
    logic                  has_addr;
    logic                  n_valid;

    assign cur_mask = r_masks[r_rec];
    assign at_end   = (r_rec == RW'(RECORDS - 1));
    assign is_self  = (r_rec == r_req);

    assign o_flags.mask_ones = &cur_mask;
    assign o_flags.mask_zero = ~|cur_mask;
    assign o_flags.at_end    = at_end;

    // Configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_size <= 13'd64;
            r_rec_size <= 8'd16;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_HEADER_SIZE: r_hdr_size <= i_cfg_data;
                REG_RECORD_SIZE: r_rec_size <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Record pointer: loaded with the request's record on every accepted request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec <= '0;
            r_req <= '0;
        end else if (i_accept) begin
            r_rec <= RW'(i_pad_index);
            r_req <= RW'(i_pad_index);
        end else begin
            case (i_ctl.rec_act)
                REC_INC:  r_rec <= at_end ? '0 : r_rec + RW'(1);
                REC_ZERO: r_rec <= '0;
                REC_REQ:  r_rec <= r_req;
                default: ;
            endcase
        end
    end

    // Mask store.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < RECORDS; i++) r_masks[i] <= '1;
        end else if (i_accept) begin
            if (i_req_ok && i_operation == OP_LOAD_MASK) begin
                r_masks[RW'(i_pad_index)] <= i_mask_value;
            end
        end else begin
            case (i_ctl.mask_act)
                MSK_SHIFT: r_masks[r_rec] <= cur_mask >> 1;
                MSK_ONES:  for (int i = 0; i < RECORDS; i++) r_masks[i] <= '1;
                default: ;
            endcase
        end
    end

    // Address pipeline, free running on the current record: byte leading
    // zeros, then slot, then product. It settles once a change of the record
    // or its mask has passed through all of these registers.
    always_comb begin
        n_slot = 7'd64;
        for (int j = 0; j < 8; j++) begin
            if (r_bnz[j]) n_slot = 7'((7 - j) * 8) + 7'(r_blz[j]);
        end
    end

    assign n_idx = IW'(r_rec) + IW'(IW'(r_slot) * IW'(RECORDS));

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 8; j++) begin
            r_bnz[j] <= |cur_mask[8*j +: 8];
            r_blz[j] <= byte_lzc(cur_mask[8*j +: 8]);
        end
        r_slot <= n_slot;
        r_prod <= PW'(n_idx) * PW'(r_rec_size);
    end

    assign sum      = SW'(r_hdr_size) + SW'(r_prod) + SW'(1);
    assign has_addr = (i_ctl.cmd == CMD_READ) || (i_ctl.cmd == CMD_WRITE);
    assign n_valid  = i_ctl.emit && !(i_ctl.skip_self && is_self);

    // Output word register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= n_valid;
        end
        o_command           <= i_ctl.cmd;
        o_address           <= has_addr ? sum[15:0] : 16'd0;
        o_beyond_sector     <= has_addr && (sum >= SW'(SECTOR_BYTES));
        o_record_pad        <= (i_ctl.cmd == CMD_ERASE) ? 3'd0 : 3'(r_rec);
        o_pad_mask          <= (i_ctl.cmd == CMD_HEADER) ? cur_mask : '0;
        o_record_from_buffer <= i_ctl.from_buf && !is_self;
        case (i_ctl.last)
            LST_YES:  o_last <= 1'b1;
            LST_LOOP: o_last <= at_end;
            default:  o_last <= 1'b0;
        endcase
    end

endmodule

/* hw/rtl/flash_record_slot_rotator.sv */
// Flash record slot rotator: turns record requests into flash command words.
// Load mask never raises busy; a write first that has to rotate runs the override program.
// Throughput: one request at a time, next start taken when busy is low; one word per cycle max.
// Reset (sync, i_rst_n low): masks all ones, header 64, record 16, idle; receiver cannot stall.
module flash_record_slot_rotator #(
    parameter int RECORDS      = 8,
    parameter int SECTOR_BYTES = 65536
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [2:0]                           i_operation,
    input  logic [2:0]                           i_pad_index,
    input  logic [frsr_pkg::MASK_W-1:0]          i_mask_value,
    input  logic                                 i_cfg_we,
    input  logic [frsr_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [frsr_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output logic                                 o_valid,
    output logic [1:0]                           o_command,
    output logic [15:0]                          o_address,
    output logic [2:0]                           o_record_pad,
    output logic [frsr_pkg::MASK_W-1:0]          o_pad_mask,
    output logic                                 o_record_from_buffer,
    output logic                                 o_beyond_sector,
    output logic                                 o_last
);
    import frsr_pkg::*;

    // The block is a small microcoded engine. A request is accepted when
    // start is high and busy is low. Load mask is handled right at the
    // accept edge and starts no program. Every other valid operation starts
    // the sequencer at its entry point in the microprogram table; each step
    // fetches one control word that drives the datapath for that cycle.
    //
    // The datapath computes a record's byte address in a three-stage pipe
    // that runs continuously on the current record pointer: leading-zero
    // count per byte of the mask, the slot number, then the product with the
    // record size. The microprogram lets three steps pass after it moves the
    // pointer or changes the mask before it emits a read or write word. The final
    // add of the header size and the sector compare happen in the emit step,
    // and the word is registered onto the outputs. Each word is on the
    // outputs for exactly one cycle, marked by o_valid.
    //
    // Requests with a record index of RECORDS or more, and unknown operations,
    // are accepted and dropped without any word; only the record pointer is loaded.

    logic   accept;
    logic   req_ok;
    t_ctl   ctl;
    t_flags flags;

    assign accept = start && !busy;
    assign req_ok = (32'(i_pad_index) < RECORDS);

    frsr_sequencer u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_operation (i_operation),
        .i_req_ok    (req_ok),
        .i_flags     (flags),
        .o_ctl       (ctl),
        .o_busy      (busy)
    );

    frsr_datapath #(
        .RECORDS      (RECORDS),
        .SECTOR_BYTES (SECTOR_BYTES)
    ) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_accept             (accept),
        .i_operation          (i_operation),
        .i_pad_index          (i_pad_index),
        .i_mask_value         (i_mask_value),
        .i_req_ok             (req_ok),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_idx            (i_cfg_idx),
        .i_cfg_data           (i_cfg_data),
        .i_ctl                (ctl),
        .o_flags              (flags),
        .o_valid              (o_valid),
        .o_command            (o_command),
        .o_address            (o_address),
        .o_record_pad         (o_record_pad),
        .o_pad_mask           (o_pad_mask),
        .o_record_from_buffer (o_record_from_buffer),
        .o_beyond_sector      (o_beyond_sector),
        .o_last               (o_last)
    );

endmodule

/* bench/flash_record_slot_rotator_tb.sv */
// Self-checking testbench of flash_record_slot_rotator: a directed table, then random request
// streams under changing geometry, all checked word by word. Depends on frsr_pkg and the RTL.
module flash_record_slot_rotator_tb;

    import frsr_pkg::*;

    localparam int          RECORDS      = 8;
    localparam int          SECTOR_BYTES = 65536;
    localparam logic [63:0] ALL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;

    // Operation codes that the block has no program for.
    localparam logic [2:0] OP_RESERVED_FIRST = 3'd5;
    localparam logic [2:0] OP_RESERVED_LAST  = 3'd7;

    localparam int IDLE_PCT      = 13;
    // Cycles allowed after the last word before the block is taken as idle.
    localparam int SETTLE_CYCLES = 16;
    // Far beyond the longest time a compaction keeps the block busy.
    localparam int STALL_LIMIT   = 2000;
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 50;

    // One flash command word as it leaves the block.
    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] address;
        logic [2:0]  record_pad;
        logic [63:0] pad_mask;
        logic        from_buffer;
        logic        beyond;
        logic        last;
    } flash_word_t;

    // One row of the directed table: either a geometry change or a request. A request row
    // may carry its single expected word typed in; otherwise the predictor supplies it.
    typedef struct packed {
        logic        is_cfg;
        logic [2:0]  op;
        logic [2:0]  pad;
        logic [63:0] mask;
        logic [12:0] hdr;
        logic [12:0] rsz;
        logic        typed;
        flash_word_t word;
    } stim_row_t;

    logic        i_clk                = 1'b0;
    logic        i_rst_n              = 1'b0;
    logic        start                = 1'b0;
    logic [2:0]  i_operation          = '0;
    logic [2:0]  i_pad_index          = '0;
    logic [63:0] i_mask_value         = '0;
    logic        i_cfg_we             = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    logic        busy;
    logic        o_valid;
    logic [1:0]  o_command;
    logic [15:0] o_address;
    logic [2:0]  o_record_pad;
    logic [63:0] o_pad_mask;
    logic        o_record_from_buffer;
    logic        o_beyond_sector;
    logic        o_last;

    // Predictor state: the slot masks and the sector geometry as the block should hold them.
    logic [63:0] mask_store [RECORDS];
    logic [12:0] hdr_bytes;
    logic [7:0]  rec_bytes;

    flash_word_t plan_q[$];     // words one request produces, built by the predictor
    flash_word_t pending_q[$];  // words still owed by the block, oldest first
    stim_row_t   table_q[$];

    int errors      = 0;
    int stall_count = 0;
    bit idle_on     = 1'b1;

    flash_record_slot_rotator #(
        .RECORDS      (RECORDS),
        .SECTOR_BYTES (SECTOR_BYTES)
    ) uut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .start                (start),
        .busy                 (busy),
        .i_operation          (i_operation),
        .i_pad_index          (i_pad_index),
        .i_mask_value         (i_mask_value),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_idx            (i_cfg_idx),
        .i_cfg_data           (i_cfg_data),
        .o_valid              (o_valid),
        .o_command            (o_command),
        .o_address            (o_address),
        .o_record_pad         (o_record_pad),
        .o_pad_mask           (o_pad_mask),
        .o_record_from_buffer (o_record_from_buffer),
        .o_beyond_sector      (o_beyond_sector),
        .o_last               (o_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------------------

    // The slot of a record is 64 minus the bit length of its thermometer mask, so an
    // all-ones mask means slot 0 and a zero mask means slot 64.
    function automatic int unsigned slot_of(input logic [63:0] m);
        int unsigned len;
        len = 0;
        for (int b = 0; b < 64; b++) begin
            if (m[b]) begin
                len = b + 1;
            end
        end
        return 64 - len;
    endfunction

    function automatic flash_word_t make_word(input logic [1:0] cmd, input logic [15:0] addr,
                                              input logic [2:0] pad, input logic [63:0] mask,
                                              input logic from_buf, input logic beyond,
                                              input logic last);
        flash_word_t w;
        w.command     = cmd;
        w.address     = addr;
        w.record_pad  = pad;
        w.pad_mask    = mask;
        w.from_buffer = from_buf;
        w.beyond      = beyond;
        w.last        = last;
        return w;
    endfunction

    // A read or write of a record at its current slot. The full address is kept wide so
    // that the sector overflow flag sees every carry out of the 16-bit port.
    function automatic flash_word_t record_word(input logic [1:0] cmd, input logic [2:0] rec,
                                                input logic from_buf);
        int unsigned full;
        full = 32'(hdr_bytes) +
               (32'(rec) + slot_of(mask_store[rec]) * RECORDS) * 32'(rec_bytes) + 1;
        return make_word(cmd, full[15:0], rec, '0, from_buf, full >= SECTOR_BYTES, 1'b0);
    endfunction

    // Sector erase followed by a header write that marks every record unused.
    task automatic plan_wipe(input logic [2:0] pad);
        plan_q.push_back(make_word(CMD_ERASE, '0, '0, '0, 1'b0, 1'b0, 1'b0));
        for (int r = 0; r < RECORDS; r++) begin
            mask_store[r] = ALL_ONES;
        end
        plan_q.push_back(make_word(CMD_HEADER, '0, pad, ALL_ONES, 1'b0, 1'b0, 1'b0));
    endtask

    // Move the record one slot up; once its mask is exhausted, the whole sector is
    // compacted: the other records are buffered, the sector wiped, and all rewritten at
    // slot 0 with only the requested record taking its data from the request.
    task automatic plan_rotate(input logic [2:0] pad);
        if (mask_store[pad] != '0) begin
            mask_store[pad] = mask_store[pad] >> 1;
            plan_q.push_back(make_word(CMD_HEADER, '0, pad, mask_store[pad], 1'b0, 1'b0, 1'b0));
            plan_q.push_back(record_word(CMD_WRITE, pad, 1'b0));
        end else begin
            for (int r = 0; r < RECORDS; r++) begin
                if (r != pad) begin
                    plan_q.push_back(record_word(CMD_READ, 3'(r), 1'b0));
                end
            end
            plan_wipe(pad);
            for (int r = 0; r < RECORDS; r++) begin
                plan_q.push_back(record_word(CMD_WRITE, 3'(r), r != pad));
            end
        end
    endtask

    // Works out every word that one accepted request produces and updates the masks.
    task automatic plan_commands(input logic [2:0] op, input logic [2:0] pad,
                                 input logic [63:0] mask);
        flash_word_t tail;
        plan_q.delete();
        case (op)
            OP_WRITE_FIRST: begin
                if (mask_store[pad] == ALL_ONES) begin
                    plan_q.push_back(record_word(CMD_WRITE, pad, 1'b0));
                end else begin
                    plan_rotate(pad);
                end
            end
            OP_OVERRIDE: plan_rotate(pad);
            OP_LOCATE:   plan_q.push_back(record_word(CMD_READ, pad, 1'b0));
            OP_FORMAT:   plan_wipe(pad);
            OP_LOAD_MASK: mask_store[pad] = mask;
            default: ;
        endcase
        if (plan_q.size() > 0) begin
            tail = plan_q.pop_back();
            tail.last = 1'b1;
            plan_q.push_back(tail);
        end
    endtask

    // ------------------------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------------------------

    // Presents one request and returns at the edge that accepts it. Start is left high so
    // that a following request can go out back to back; it is lowered only for an idle gap.
    // The words owed are the predictor's, or the single typed word where one is given.
    task automatic send_request(input logic [2:0] op, input logic [2:0] pad,
                                input logic [63:0] mask, input logic typed,
                                input flash_word_t word);
        int gap;
        gap = 0;
        while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
            gap++;
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_operation  <= op;
        i_pad_index  <= pad;
        i_mask_value <= mask;
        do @(posedge i_clk); while (busy);
        plan_commands(op, pad, mask);
        if (typed) begin
            pending_q.push_back(word);
        end else begin
            foreach (plan_q[k]) begin
                pending_q.push_back(plan_q[k]);
            end
        end
    endtask

    task automatic request(input logic [2:0] op, input logic [2:0] pad, input logic [63:0] mask);
        send_request(op, pad, mask, 1'b0, '0);
    endtask

    // Lowers start and waits until every owed word has come and the block is idle. Load
    // mask and reserved operations produce no word, so a few more cycles are let pass.
    task automatic drain();
        start <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        while (busy) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes both geometry registers, header size first, then record size. Only called while idle.
    task automatic set_geometry(input logic [12:0] hdr, input logic [12:0] rsz);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_HEADER_SIZE;
        i_cfg_data <= hdr;
        @(posedge i_clk);
        hdr_bytes = hdr;
        i_cfg_idx  <= REG_RECORD_SIZE;
        i_cfg_data <= rsz;
        @(posedge i_clk);
        rec_bytes = rsz[7:0];
        i_cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------------------------
    // Directed table rows
    // ------------------------------------------------------------------------------------

    function automatic stim_row_t cfg_row(input logic [12:0] hdr, input logic [12:0] rsz);
        stim_row_t r;
        r        = '0;
        r.is_cfg = 1'b1;
        r.hdr    = hdr;
        r.rsz    = rsz;
        return r;
    endfunction

    function automatic stim_row_t req_row(input logic [2:0] op, input logic [2:0] pad,
                                          input logic [63:0] mask);
        stim_row_t r;
        r      = '0;
        r.op   = op;
        r.pad  = pad;
        r.mask = mask;
        return r;
    endfunction

    function automatic stim_row_t known_row(input logic [2:0] op, input logic [2:0] pad,
                                            input flash_word_t word);
        stim_row_t r;
        r       = req_row(op, pad, '0);
        r.typed = 1'b1;
        r.word  = word;
        return r;
    endfunction

    // Picks a geometry setting: every fourth phase an extreme, otherwise a random point in
    // range. The record size write carries random upper bits that the block must drop.
    task automatic pick_geometry(input int phase);
        logic [12:0] hdr;
        logic [12:0] rsz;
        if (phase % 4 == 0) begin
            case ($urandom_range(0, 2))
                0: hdr = 13'd0;
                1: hdr = 13'd4096;
                default: hdr = 13'h1FFF;
            endcase
            case ($urandom_range(0, 2))
                0: rsz = 13'd1;
                1: rsz = 13'd255;
                default: rsz = 13'($urandom_range(0, 31)) << 8;
            endcase
        end else begin
            hdr = 13'($urandom_range(0, 4096));
            rsz = 13'($urandom_range(0, 8191));
        end
        set_geometry(hdr, rsz);
    endtask

    // ------------------------------------------------------------------------------------
    // Result checking: every word on the ports is taken at the edge that ends its cycle and
    // compared with the oldest owed word.
    // ------------------------------------------------------------------------------------

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        flash_word_t want;
        if (i_rst_n && o_valid) begin
            if (pending_q.size() == 0) begin
                $error("word with no request behind it: command %0d address %0h",
                       o_command, o_address);
                errors++;
            end else begin
                want = pending_q.pop_front();
                check_field("command", 64'(want.command), 64'(o_command));
                check_field("address", 64'(want.address), 64'(o_address));
                check_field("record_pad", 64'(want.record_pad), 64'(o_record_pad));
                check_field("pad_mask", want.pad_mask, o_pad_mask);
                check_field("record_from_buffer", 64'(want.from_buffer),
                            64'(o_record_from_buffer));
                check_field("beyond_sector", 64'(want.beyond), 64'(o_beyond_sector));
                check_field("last", 64'(want.last), 64'(o_last));
            end
        end
    end

    // Watchdog: a run in which neither a request nor a word moves for this long is hung.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid || (start && !busy)) begin
                stall_count <= 0;
            end else begin
                stall_count <= stall_count + 1;
                if (stall_count >= STALL_LIMIT) begin
                    $display("*** FAILED ***");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------------------

    initial begin
        int          counted;
        int          pick;
        int          depth;
        logic [2:0]  pad;
        logic [63:0] noise;

        for (int r = 0; r < RECORDS; r++) begin
            mask_store[r] = ALL_ONES;
        end
        hdr_bytes = 13'd64;
        rec_bytes = 8'd16;

        // Directed part. Typed words are for the reset geometry (64-byte header, 16-byte
        // records) or for the geometry the row just before sets.
        // A first write of an unused record lands at slot 0: 64 + 0 + 1.
        table_q.push_back(known_row(OP_WRITE_FIRST, 3'd0,
                          make_word(CMD_WRITE, 16'd65, 3'd0, '0, 1'b0, 1'b0, 1'b1)));
        // Highest record at slot 0: 64 + 7*16 + 1.
        table_q.push_back(known_row(OP_LOCATE, 3'd7,
                          make_word(CMD_READ, 16'd177, 3'd7, '0, 1'b0, 1'b0, 1'b1)));
        table_q.push_back(req_row(OP_OVERRIDE, 3'd0, '0));
        // A first write of a record already in use behaves as an override.
        table_q.push_back(req_row(OP_WRITE_FIRST, 3'd0, '0));
        // An exhausted mask puts the record at slot 64: 64 + (3 + 512)*16 + 1.
        table_q.push_back(req_row(OP_LOAD_MASK, 3'd3, '0));
        table_q.push_back(known_row(OP_LOCATE, 3'd3,
                          make_word(CMD_READ, 16'd8305, 3'd3, '0, 1'b0, 1'b0, 1'b1)));
        // Override of an exhausted mask: full compaction.
        table_q.push_back(req_row(OP_OVERRIDE, 3'd3, '0));
        table_q.push_back(req_row(OP_FORMAT, 3'd5, '0));
        // Reserved operations are dropped without a word.
        table_q.push_back(req_row(OP_RESERVED_FIRST, 3'd1, ALL_ONES));
        table_q.push_back(req_row(OP_RESERVED_FIRST + 3'd1, 3'd2, ALL_ONES));
        table_q.push_back(req_row(OP_RESERVED_LAST, 3'd6, ALL_ONES));
        // Last slot step to a zero mask, then a first write that has to compact.
        table_q.push_back(req_row(OP_LOAD_MASK, 3'd1, 64'd1));
        table_q.push_back(req_row(OP_OVERRIDE, 3'd1, '0));
        table_q.push_back(req_row(OP_WRITE_FIRST, 3'd1, '0));
        // Largest geometry: 8191 + (7 + 512)*255 + 1 overflows the sector and wraps to 9465.
        table_q.push_back(cfg_row(13'h1FFF, 13'd255));
        table_q.push_back(req_row(OP_LOAD_MASK, 3'd7, '0));
        table_q.push_back(known_row(OP_LOCATE, 3'd7,
                          make_word(CMD_READ, 16'd9465, 3'd7, '0, 1'b0, 1'b1, 1'b1)));
        table_q.push_back(req_row(OP_OVERRIDE, 3'd7, '0));
        // Zero header and zero record size: every record sits at address 1.
        table_q.push_back(cfg_row(13'd0, 13'd0));
        table_q.push_back(known_row(OP_LOCATE, 3'd2,
                          make_word(CMD_READ, 16'd1, 3'd2, '0, 1'b0, 1'b0, 1'b1)));
        table_q.push_back(req_row(OP_LOAD_MASK, 3'd6, 64'h8000_0000_0000_0000));
        table_q.push_back(req_row(OP_WRITE_FIRST, 3'd6, '0));
        // Top of the header range with one-byte records: 4096 + 4 + 1.
        table_q.push_back(cfg_row(13'd4096, 13'd1));
        table_q.push_back(known_row(OP_LOCATE, 3'd4,
                          make_word(CMD_READ, 16'd4101, 3'd4, '0, 1'b0, 1'b0, 1'b1)));
        table_q.push_back(req_row(OP_FORMAT, 3'd0, '0));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (table_q[k]) begin
            if (table_q[k].is_cfg) begin
                drain();
                set_geometry(table_q[k].hdr, table_q[k].rsz);
            end else begin
                send_request(table_q[k].op, table_q[k].pad, table_q[k].mask,
                             table_q[k].typed, table_q[k].word);
            end
        end

        // Random part: each phase starts from an idle block with a new geometry. Most of the
        // stream restores a nearly spent mask and then rotates that record, often far enough to wrap into
        // a compaction; the rest is single requests, arbitrary masks and reserved codes.
        for (int phase = 0; phase < PHASES; phase++) begin
            drain();
            pick_geometry(phase);
            // Two phases run with no gaps at all from the sender.
            idle_on = !(phase == 4 || phase == 5);
            counted = 0;
            while (counted < PHASE_ITEMS) begin
                pick  = $urandom_range(0, 99);
                pad   = 3'($urandom_range(0, RECORDS - 1));
                noise = {$urandom, $urandom};
                if (pick < 50) begin
                    if ($urandom_range(0, 3) == 0) begin
                        request(OP_LOAD_MASK, pad, ALL_ONES >> $urandom_range(0, 64));
                    end else begin
                        request(OP_LOAD_MASK, pad, ALL_ONES >> (64 - $urandom_range(0, 3)));
                    end
                    depth = $urandom_range(1, 4);
                    for (int s = 0; s < depth; s++) begin
                        request($urandom_range(0, 1) ? OP_OVERRIDE : OP_WRITE_FIRST, pad, noise);
                    end
                    counted += depth + 1;
                end else if (pick < 65) begin
                    request(OP_LOCATE, pad, noise);
                    counted++;
                end else if (pick < 72) begin
                    request(OP_FORMAT, pad, noise);
                    counted++;
                end else if (pick < 82) begin
                    // Arbitrary bit pattern: the slot follows the highest set bit only.
                    request(OP_LOAD_MASK, pad, noise);
                    request(OP_LOCATE, pad, ~noise);
                    counted += 2;
                end else if (pick < 93) begin
                    request($urandom_range(0, 1) ? OP_WRITE_FIRST : OP_OVERRIDE, pad, noise);
                    counted++;
                end else begin
                    request(3'($urandom_range(OP_RESERVED_FIRST, OP_RESERVED_LAST)), pad, noise);
                end
            end
        end

        drain();
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
